>>> rtl/core/htbd_pkg.sv
`timescale 1ns / 1ps
package htbd_pkg;
  localparam int MaxLeaves  = 64;
  localparam int WeightBits = 16;
  localparam int NodeSlots  = 128;
  localparam int IdxW       = 7;
  localparam int SumW       = WeightBits + 7;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_BUILD  = 2'd1;
  localparam logic [1:0] FUNC_DECODE = 2'd2;
  localparam logic [1:0] FUNC_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MID   = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [7:0] CharLeft  = 8'd48;
  localparam logic [7:0] CharRight = 8'd49;

  typedef struct packed {
    logic           valid;
    logic [7:0]     symbol;
    logic [62:0]    code_bits;
    logic [5:0]     code_length;
    logic [1:0]     status;
  } result_t;

  // Running pair of smallest candidates for one merge step.
  typedef struct packed {
    logic            ha;
    logic            hb;
    logic [IdxW-1:0] a;
    logic [IdxW-1:0] b;
    logic [SumW-1:0] wa;
    logic [SumW-1:0] wb;
  } pick_t;
endpackage

>>> rtl/core/huffman_tree_build_and_decode_unit.sv
`timescale 1ns / 1ps
// A load, a refused build or query, and a decode character that leaves the walk alone present
// their result from the output state; a character that moves the walk makes two reads first.
// A build of n leaves runs a clear pass, then merge i scans the i-1 earlier nodes through one
// shared two-smallest compare unit. A query walks up from the leaf one tree level at a time;
// one transaction at a time, the next is accepted the cycle after the result is taken. Reset
// clears leaf count, tree flag and the decode walk; node tables are not cleared.
module huffman_tree_build_and_decode_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: leaf_weight[15:0], leaf_symbol[23:16], code_char[31:24],
  //        leaf_index[37:32], zero fill [39:38]
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // end_of_string
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: symbol_valid[0], symbol[8:1], code_bits[71:9], code_length[77:72],
  //        status[79:78]
  output logic [79:0] m_axis_tdata
);
  localparam int IW = htbd_pkg::IdxW;
  localparam int SW = htbd_pkg::SumW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_SCANW = 4'd3;
  localparam logic [3:0] S_MERGE = 4'd4;
  localparam logic [3:0] S_QRD   = 4'd5;
  localparam logic [3:0] S_QCHK  = 4'd6;
  localparam logic [3:0] S_DRD   = 4'd7;
  localparam logic [3:0] S_DRD2  = 4'd8;
  localparam logic [3:0] S_DCHK  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_QUP   = 4'd11;

  logic [SW-1:0] wmem [htbd_pkg::NodeSlots];
  logic [IW-1:0] pmem [htbd_pkg::NodeSlots];
  logic [IW-1:0] lmem [htbd_pkg::NodeSlots];
  logic [IW-1:0] rmem [htbd_pkg::NodeSlots];
  logic [7:0]    smem [htbd_pkg::NodeSlots];

  logic [3:0]    state_q, state_d;
  logic [IW-1:0] leaf_cnt_q;
  logic          built_q, failed_q, on_leaf_q;
  logic [IW-1:0] walk_q;
  logic [IW-1:0] i_q, j_q, c_q;
  logic [5:0]    depth_q;
  logic [62:0]   bits_q;
  logic [7:0]    ch_q;
  logic          last_q;
  htbd_pkg::pick_t pick_q, pick_nxt;
  htbd_pkg::result_t res_q;
  logic [1:0]    merge_ph_q;

  // Registered read data.
  logic [SW-1:0] rd_w;
  logic [IW-1:0] rd_p, rd_l, rd_r;
  logic [7:0]    rd_s;
  logic [IW-1:0] rd_addr;
  logic          scan_vld_q;
  logic [IW-1:0] scan_idx_q;
  logic [IW-1:0] rd_addr_q;
  logic          s_last_dec_q;
  logic          leaf_hit;
  logic          fail_fin, on_fin;

  logic [IW-1:0] total;
  assign total = IW'({leaf_cnt_q, 1'b0} - 8'd1);

  logic acc;
  assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;
  assign acc = s_axis_tvalid && s_axis_tready;

  htbd_min2 u_min2 (
    .cur_i (pick_q),
    .en_i  (scan_vld_q && (rd_p == '0)),
    .idx_i (scan_idx_q),
    .w_i   (rd_w),
    .nxt_o (pick_nxt)
  );

  // Read address selection.
  always_comb begin
    case (state_q)
      S_SCAN:  rd_addr = j_q;
      S_QRD:   rd_addr = c_q;
      S_QCHK:  rd_addr = rd_p;
      S_QUP:   rd_addr = rd_addr_q;
      S_DRD:   rd_addr = walk_q;
      S_DRD2:  rd_addr = (ch_q == htbd_pkg::CharLeft) ? rd_l : rd_r;
      default: rd_addr = c_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_w <= wmem[rd_addr];
    rd_p <= pmem[rd_addr];
    rd_l <= lmem[rd_addr];
    rd_r <= rmem[rd_addr];
    rd_s <= smem[rd_addr];
  end

  // Memory writes.
  always_ff @(posedge clk_i) begin
    if (acc && s_axis_tuser == htbd_pkg::FUNC_LOAD) begin
      if (built_q) begin
        wmem[1] <= SW'(s_axis_tdata[15:0]);
        smem[1] <= s_axis_tdata[23:16];
      end else if (leaf_cnt_q < IW'(htbd_pkg::MaxLeaves)) begin
        wmem[leaf_cnt_q + 1'b1] <= SW'(s_axis_tdata[15:0]);
        smem[leaf_cnt_q + 1'b1] <= s_axis_tdata[23:16];
      end
    end
    if (state_q == S_CLR) begin
      pmem[i_q] <= '0;
      lmem[i_q] <= '0;
      rmem[i_q] <= '0;
    end
    if (state_q == S_MERGE) begin
      case (merge_ph_q)
        2'd0: begin
          pmem[pick_q.a] <= i_q;
          lmem[i_q] <= pick_q.a;
          rmem[i_q] <= pick_q.b;
          wmem[i_q] <= pick_q.wa + pick_q.wb;
        end
        default: pmem[pick_q.b] <= i_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (s_axis_tuser)
            htbd_pkg::FUNC_LOAD:   state_d = S_OUT;
            htbd_pkg::FUNC_BUILD:
              state_d = (leaf_cnt_q < IW'(2)) ? S_OUT : S_CLR;
            htbd_pkg::FUNC_QUERY:
              state_d = (!built_q || {1'b0, s_axis_tdata[37:32]} >= leaf_cnt_q) ?
                        S_OUT : S_QRD;
            default:
              state_d = (failed_q) ? S_OUT :
                        (built_q && (s_axis_tdata[31:24] == htbd_pkg::CharLeft ||
                         s_axis_tdata[31:24] == htbd_pkg::CharRight)) ? S_DRD : S_OUT;
          endcase
        end
      end
      S_CLR:   if (i_q == total) state_d = S_SCAN;
      S_SCAN:  if (j_q == i_q - 1'b1) state_d = S_SCANW;
      S_SCANW: state_d = S_MERGE;
      S_MERGE: if (merge_ph_q != 2'd0) state_d = (i_q == total) ? S_OUT : S_SCAN;
      S_QRD:   state_d = S_QCHK;
      S_QCHK:  state_d = (rd_p == '0 || depth_q == 6'd63) ? S_OUT : S_QUP;
      S_QUP:   state_d = S_QCHK;
      S_DRD:   state_d = S_DRD2;
      S_DRD2:  state_d = S_DCHK;
      S_DCHK:  state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      leaf_cnt_q <= '0;
      built_q    <= 1'b0;
      failed_q   <= 1'b0;
      on_leaf_q  <= 1'b1;
      walk_q     <= '0;
      m_axis_tvalid <= 1'b0;
      scan_vld_q <= 1'b0;
      merge_ph_q <= '0;
    end else begin
      state_q <= state_d;
      scan_vld_q <= (state_q == S_SCAN);
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (state_q == S_OUT) m_axis_tvalid <= 1'b1;
      if (state_q == S_MERGE) merge_ph_q <= merge_ph_q + 2'd1;
      else merge_ph_q <= '0;
      if (acc) begin
        case (s_axis_tuser)
          htbd_pkg::FUNC_LOAD: begin
            if (built_q) begin
              leaf_cnt_q <= IW'(1);
              built_q    <= 1'b0;
              walk_q     <= '0;
              failed_q   <= 1'b0;
              on_leaf_q  <= 1'b1;
            end else if (leaf_cnt_q < IW'(htbd_pkg::MaxLeaves)) begin
              leaf_cnt_q <= leaf_cnt_q + 1'b1;
            end
          end
          htbd_pkg::FUNC_DECODE: begin
            if (!failed_q && !(built_q &&
                (s_axis_tdata[31:24] == htbd_pkg::CharLeft ||
                 s_axis_tdata[31:24] == htbd_pkg::CharRight)))
              failed_q <= 1'b1;
          end
          default: ;
        endcase
      end
      if (state_q == S_MERGE && merge_ph_q != 2'd0 && i_q == total) begin
        built_q   <= 1'b1;
        walk_q    <= total;
        failed_q  <= 1'b0;
        on_leaf_q <= 1'b1;
      end
      if (state_q == S_DCHK) begin
        if (rd_l == '0 && rd_r == '0) begin
          walk_q <= total;
          on_leaf_q <= 1'b1;
        end else begin
          walk_q <= rd_addr_q;
          on_leaf_q <= 1'b0;
        end
      end
      // End of string: close out and return to the root.
      if (state_q == S_OUT && res_q.status != htbd_pkg::ST_MID &&
          s_last_dec_q) begin
        walk_q    <= built_q ? total : '0;
        failed_q  <= 1'b0;
        on_leaf_q <= 1'b1;
      end
    end
  end

  assign leaf_hit = (rd_l == '0 && rd_r == '0);

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ch_q   <= s_axis_tdata[31:24];
      last_q <= s_axis_tlast;
      s_last_dec_q <= (s_axis_tuser == htbd_pkg::FUNC_DECODE) && s_axis_tlast;
      res_q  <= '0;
      depth_q <= '0;
      bits_q <= '0;
      c_q    <= IW'({1'b0, s_axis_tdata[37:32]} + 7'd1);
      case (s_axis_tuser)
        htbd_pkg::FUNC_LOAD:
          res_q.status <= (!built_q && leaf_cnt_q >= IW'(htbd_pkg::MaxLeaves)) ?
                          htbd_pkg::ST_ERROR : htbd_pkg::ST_OK;
        htbd_pkg::FUNC_BUILD: begin
          res_q.status <= (leaf_cnt_q < IW'(2)) ? htbd_pkg::ST_ERROR : htbd_pkg::ST_OK;
          i_q <= IW'(1);
        end
        htbd_pkg::FUNC_QUERY:
          res_q.status <= (!built_q || {1'b0, s_axis_tdata[37:32]} >= leaf_cnt_q) ?
                          htbd_pkg::ST_ERROR : htbd_pkg::ST_OK;
        default:
          res_q.status <= !s_axis_tlast ? htbd_pkg::ST_MID : htbd_pkg::ST_OK;
      endcase
    end
    case (state_q)
      S_CLR: begin
        if (i_q == total) begin
          i_q <= leaf_cnt_q + 1'b1;
          j_q <= IW'(1);
          pick_q <= '0;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      S_SCAN: begin
        j_q <= j_q + 1'b1;
        scan_idx_q <= j_q;
      end
      S_MERGE: begin
        if (merge_ph_q != 2'd0) begin
          i_q <= i_q + 1'b1;
          j_q <= IW'(1);
          pick_q <= '0;
        end
      end
      S_QCHK: begin
        if (rd_p == '0 || depth_q == 6'd63) begin
          res_q.code_bits   <= bits_q;
          res_q.code_length <= depth_q;
        end
      end
      // Read data now holds the parent row; the child is still in c_q.
      S_QUP: begin
        if (rd_r == c_q) bits_q[depth_q] <= 1'b1;
        depth_q <= depth_q + 1'b1;
        c_q <= rd_addr_q;
      end
      S_DCHK: begin
        c_q <= rd_addr_q;
        if (leaf_hit) begin
          res_q.valid  <= 1'b1;
          res_q.symbol <= rd_s;
        end
      end
      default: ;
    endcase
    if (scan_vld_q) pick_q <= pick_nxt;
    if (state_q == S_OUT && last_q && res_q.status != htbd_pkg::ST_MID) begin
      m_axis_tdata <= {res_q.status == htbd_pkg::ST_MID ? htbd_pkg::ST_MID :
                       (s_last_dec_q ? ((fail_fin || !on_fin) ? htbd_pkg::ST_ERROR :
                       htbd_pkg::ST_OK) : res_q.status),
                       res_q.code_length, res_q.code_bits, res_q.symbol, res_q.valid};
    end else if (state_q == S_OUT) begin
      m_axis_tdata <= {res_q.status, res_q.code_length, res_q.code_bits,
                       res_q.symbol, res_q.valid};
    end
  end

  // Walk address registered for the DCHK step.
  always_ff @(posedge clk_i) rd_addr_q <= rd_addr;

  // Failure and leaf state as they stand once this character is resolved.
  assign fail_fin = failed_q;
  assign on_fin   = on_leaf_q;

  property p_busy_not_ready;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != S_IDLE) |-> !s_axis_tready;
  endproperty
  assert property (p_busy_not_ready) else $error("ready while busy");

  property p_one_result;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_OUT) |=> m_axis_tvalid;
  endproperty
  assert property (p_one_result) else $error("result not presented");

  property p_root_after_build;
    @(posedge clk_i) disable iff (!rst_ni)
      ($rose(built_q)) |-> (walk_q == total && !failed_q);
  endproperty
  assert property (p_root_after_build) else $error("walk not at root after build");
endmodule

>>> rtl/core/htbd_min2.sv
`timescale 1ns / 1ps
// Shared compare unit: folds one candidate node into the two-smallest pair.
module htbd_min2 (
  input  htbd_pkg::pick_t             cur_i,
  input  logic                        en_i,
  input  logic [htbd_pkg::IdxW-1:0]   idx_i,
  input  logic [htbd_pkg::SumW-1:0]   w_i,
  output htbd_pkg::pick_t             nxt_o
);
  always_comb begin
    nxt_o = cur_i;
    if (en_i) begin
      if (!cur_i.ha || w_i < cur_i.wa) begin
        nxt_o.b  = cur_i.a;
        nxt_o.wb = cur_i.wa;
        nxt_o.hb = cur_i.ha;
        nxt_o.a  = idx_i;
        nxt_o.wa = w_i;
        nxt_o.ha = 1'b1;
      end else if (!cur_i.hb || w_i < cur_i.wb) begin
        nxt_o.b  = idx_i;
        nxt_o.wb = w_i;
        nxt_o.hb = 1'b1;
      end
    end
  end
endmodule

>>> test/tb_huffman_tree_build_and_decode_unit.sv
`timescale 1ns / 1ps
module tb_huffman_tree_build_and_decode_unit;

  localparam int CycleLimit = 2000000;

  typedef struct {
    logic        valid;
    logic [7:0]  symbol;
    logic [62:0] bits;
    logic [5:0]  length;
    logic [1:0]  status;
  } decode_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic [1:0]  s_axis_tuser = htbd_pkg::FUNC_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  huffman_tree_build_and_decode_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the node table and the decoder walk.
  longint unsigned node_wt[htbd_pkg::NodeSlots];
  int unsigned     node_up[htbd_pkg::NodeSlots];
  int unsigned     node_lo[htbd_pkg::NodeSlots];
  int unsigned     node_hi[htbd_pkg::NodeSlots];
  logic [7:0]      node_sym[htbd_pkg::NodeSlots];
  int unsigned     n_leaves = 0;
  int unsigned     walk_at = 0;
  bit              str_bad = 0;
  bit              at_leaf = 1;
  bit              tree_ok = 0;

  decode_result_t  pending_results[$];
  int              errors = 0;
  int              items_sent = 0;
  bit              idle_on = 1;
  int              hold_off = 0;

  function automatic int unsigned root_node();
    return (2 * n_leaves - 1) & (htbd_pkg::NodeSlots - 1);
  endfunction

  function automatic void restart_walk();
    walk_at = tree_ok ? root_node() : 0;
    str_bad = 0;
    at_leaf = 1;
  endfunction

  function automatic logic [1:0] merge_nodes();
    int unsigned total, a, b;
    longint unsigned wa, wb;
    bit ha, hb;
    if (n_leaves < 2 || n_leaves > htbd_pkg::MaxLeaves) return htbd_pkg::ST_ERROR;
    total = 2 * n_leaves - 1;
    for (int unsigned i = 1; i <= total; i++) begin
      if (i > n_leaves) node_wt[i] = 0;
      node_up[i] = 0;
      node_lo[i] = 0;
      node_hi[i] = 0;
    end
    for (int unsigned i = n_leaves + 1; i <= total; i++) begin
      a = 0; b = 0; wa = 0; wb = 0; ha = 0; hb = 0;
      for (int unsigned j = 1; j < i; j++) begin
        if (node_up[j] != 0) continue;
        if (!ha || node_wt[j] < wa) begin
          b = a; wb = wa; hb = ha;
          a = j; wa = node_wt[j]; ha = 1;
        end else if (!hb || node_wt[j] < wb) begin
          b = j; wb = node_wt[j]; hb = 1;
        end
      end
      node_up[a] = i;
      node_up[b] = i;
      node_lo[i] = a;
      node_hi[i] = b;
      node_wt[i] = wa + wb;
    end
    tree_ok = 1;
    restart_walk();
    return htbd_pkg::ST_OK;
  endfunction

  // Code of one leaf; bit 0 is the branch taken just above the leaf.
  function automatic void leaf_code(input int unsigned idx, output logic [62:0] bits,
                                    output int unsigned len);
    int unsigned c, f;
    bits = '0;
    len = 0;
    c = idx + 1;
    f = node_up[c];
    while (f != 0 && len < 63) begin
      if (node_hi[f] == c) bits[len] = 1'b1;
      len++;
      c = f;
      f = node_up[f & (htbd_pkg::NodeSlots - 1)];
    end
  endfunction

  function automatic decode_result_t predict_result(input logic [1:0] fn, input logic [15:0] w,
                                                    input logic [7:0] sy, input logic [7:0] ch,
                                                    input logic eos, input logic [5:0] qi);
    decode_result_t r;
    int unsigned p, c, len;
    r = '{1'b0, 8'd0, 63'd0, 6'd0, htbd_pkg::ST_OK};
    case (fn)
      htbd_pkg::FUNC_LOAD: begin
        if (tree_ok) begin
          n_leaves = 0;
          tree_ok = 0;
          restart_walk();
        end
        if (n_leaves >= htbd_pkg::MaxLeaves) begin
          r.status = htbd_pkg::ST_ERROR;
        end else begin
          n_leaves++;
          node_wt[n_leaves] = 64'(w);
          node_sym[n_leaves] = sy;
        end
      end
      htbd_pkg::FUNC_BUILD: r.status = merge_nodes();
      htbd_pkg::FUNC_QUERY: begin
        if (!tree_ok || qi >= n_leaves) begin
          r.status = htbd_pkg::ST_ERROR;
        end else begin
          leaf_code(qi, r.bits, len);
          r.length = len[5:0];
        end
      end
      default: begin
        if (!str_bad) begin
          if (tree_ok && (ch == htbd_pkg::CharLeft || ch == htbd_pkg::CharRight)) begin
            p = walk_at & (htbd_pkg::NodeSlots - 1);
            c = ((ch == htbd_pkg::CharLeft) ? node_lo[p] : node_hi[p]) &
                (htbd_pkg::NodeSlots - 1);
            if (node_lo[c] == 0 && node_hi[c] == 0) begin
              r.valid = 1'b1;
              r.symbol = node_sym[c];
              walk_at = root_node();
              at_leaf = 1;
            end else begin
              walk_at = c;
              at_leaf = 0;
            end
          end else begin
            str_bad = 1;
          end
        end
        if (eos) begin
          r.status = (str_bad || !at_leaf) ? htbd_pkg::ST_ERROR : htbd_pkg::ST_OK;
          restart_walk();
        end else begin
          r.status = htbd_pkg::ST_MID;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [1:0] fn, input logic [15:0] w, input logic [7:0] sy,
                           input logic [7:0] ch, input logic eos, input logic [5:0] qi);
    @(negedge clk_i);
    s_axis_tuser = fn;
    s_axis_tdata = {2'b00, qi, ch, sy, w};
    s_axis_tlast = eos;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_result(fn, w, sy, ch, eos, qi));
    items_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  endtask

  task automatic load_leaf(input logic [15:0] w, input logic [7:0] sy);
    send_item(htbd_pkg::FUNC_LOAD, w, sy, 8'($urandom), 1'($urandom), 6'($urandom));
  endtask

  task automatic build_tree();
    send_item(htbd_pkg::FUNC_BUILD, 16'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom), 6'($urandom));
  endtask

  task automatic query_leaf(input logic [5:0] qi);
    send_item(htbd_pkg::FUNC_QUERY, 16'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom), qi);
  endtask

  task automatic code_char(input logic [7:0] ch, input logic eos);
    send_item(htbd_pkg::FUNC_DECODE, 16'($urandom), 8'($urandom), ch, eos, 6'($urandom));
  endtask

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // One code string built from the codes of several leaves; optionally damaged
  // by a bad character or by cutting the last character off.
  task automatic send_code_string(input int n_syms, input bit put_bad, input bit cut_short);
    logic [62:0] bits;
    int unsigned len;
    logic [7:0] chars[$];
    int bad_at;
    for (int s = 0; s < n_syms; s++) begin
      leaf_code($urandom_range(0, n_leaves - 1), bits, len);
      for (int k = int'(len) - 1; k >= 0; k--)
        chars.push_back(bits[k] ? htbd_pkg::CharRight : htbd_pkg::CharLeft);
    end
    if (cut_short && chars.size() > 1) void'(chars.pop_back());
    if (put_bad) begin
      bad_at = $urandom_range(0, chars.size() - 1);
      do chars[bad_at] = 8'($urandom);
      while (chars[bad_at] == htbd_pkg::CharLeft || chars[bad_at] == htbd_pkg::CharRight);
    end
    foreach (chars[k]) code_char(chars[k], k == chars.size() - 1);
  endtask

  task automatic test_empty_table();
    code_char(htbd_pkg::CharLeft, 1'b0);
    code_char(htbd_pkg::CharRight, 1'b1);
    build_tree();
    query_leaf(6'd0);
    load_leaf(16'h0000, 8'h00);
    build_tree();
    query_leaf(6'd0);
  endtask

  task automatic test_small_tree();
    load_leaf(16'hFFFF, 8'hFF);
    load_leaf(16'h0001, 8'hA5);
    load_leaf(16'h0001, 8'h5A);
    build_tree();
    for (int i = 0; i < 4; i++) query_leaf(i[5:0]);
    query_leaf(6'd63);
  endtask

  task automatic test_decode_cases();
    send_code_string(3, 0, 0);
    send_code_string(2, 1, 0);
    send_code_string(2, 0, 1);
    code_char(8'hFF, 1'b1);
    code_char(8'h00, 1'b0);
    code_char(htbd_pkg::CharLeft, 1'b1);
    build_tree();
    send_code_string(1, 0, 0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < htbd_pkg::MaxLeaves; i++) load_leaf(pick_weight(), 8'($urandom));
    load_leaf(16'h1234, 8'h77);
    build_tree();
    query_leaf(6'd63);
    query_leaf(6'd0);
    send_code_string(4, 0, 0);
    load_leaf(16'h0002, 8'h11);
    query_leaf(6'd0);
  endtask

  task automatic test_backpressure();
    load_leaf(16'd5, 8'h21);
    load_leaf(16'd9, 8'h22);
    load_leaf(16'd1, 8'h23);
    build_tree();
    hold_off = 300;
    for (int i = 0; i < 8; i++) send_code_string(1, 0, 0);
  endtask

  task automatic test_random_sessions();
    int n;
    while (items_sent < 1550) begin
      if (items_sent > 1350) idle_on = 0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(2, 10);
      for (int i = 0; i < n; i++) load_leaf(pick_weight(), 8'($urandom));
      build_tree();
      if (!tree_ok) continue;
      repeat ($urandom_range(1, 4)) query_leaf(6'($urandom_range(0, n_leaves)));
      repeat ($urandom_range(3, 8)) begin
        case ($urandom_range(0, 9))
          0: send_code_string($urandom_range(1, 4), 1, 0);
          1: send_code_string($urandom_range(1, 4), 0, 1);
          2: code_char(8'($urandom), 1'($urandom));
          default: send_code_string($urandom_range(1, 4), 0, 0);
        endcase
      end
    end
  endtask

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        m_axis_tready = 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    decode_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.valid || m_axis_tdata[8:1] !== want.symbol
            || m_axis_tdata[71:9] !== want.bits || m_axis_tdata[77:72] !== want.length
            || m_axis_tdata[79:78] !== want.status) begin
          $display("%0t: mismatch, expected valid %b sym %h bits %h len %0d st %0d",
                   $time, want.valid, want.symbol, want.bits, want.length, want.status);
          $display("%0t:          actual   valid %b sym %h bits %h len %0d st %0d",
                   $time, m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[71:9],
                   m_axis_tdata[77:72], m_axis_tdata[79:78]);
          errors++;
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("tb_huffman_tree_build_and_decode_unit: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_table();
    test_small_tree();
    test_decode_cases();
    test_full_table();
    test_backpressure();
    test_random_sessions();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_huffman_tree_build_and_decode_unit: PASS");
    end else begin
      $display("tb_huffman_tree_build_and_decode_unit: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/htbd_pkg.sv
rtl/core/htbd_min2.sv
rtl/core/huffman_tree_build_and_decode_unit.sv
test/tb_huffman_tree_build_and_decode_unit.sv
